// ===== hdl/cmig_pkg.sv =====
// cmig_pkg: shared types and constants for the cylinder mesh index generator
// used by cmig_walk, cmig_skid and cylinder_mesh_index_generator; no dependencies
`default_nettype none

package cmig_pkg;

  // segment count limits
  localparam int MAX_AROUND = 256;
  localparam int MAX_ALONG  = 256;
  localparam int MIN_AROUND = 3;
  localparam int MIN_ALONG  = 1;

  // widths
  localparam int CNT_W     = 9;   // segment counts and ring level
  localparam int SEG_W     = 8;   // segment index
  localparam int IDX_W     = 17;  // vertex index
  localparam int CFG_IDX_W = 2;   // configuration register index
  localparam int CFG_W     = 9;   // widest configuration register
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 56; // three vertex indices padded to bytes

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AROUND       = 2'd0,
    CFG_ALONG        = 2'd1,
    CFG_CLOSE_BOTTOM = 2'd2,
    CFG_CLOSE_TOP    = 2'd3
  } cfg_idx_t;

  // walk phase
  typedef enum logic [1:0] {
    PH_SIDE   = 2'd0,
    PH_BOTTOM = 2'd1,
    PH_TOP    = 2'd2
  } phase_t;

  // one triangle
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] vertex_c;
    logic [IDX_W-1:0] vertex_b;
    logic [IDX_W-1:0] vertex_a;
  } tri_t;

endpackage

`default_nettype wire

// ===== hdl/cmig_walk.sv =====
// cmig_walk: configuration registers, walk counters and triangle index logic
// depends on cmig_pkg
`default_nettype none

module cmig_walk (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wen,
  input  wire logic [cmig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cmig_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          step,
  input  wire logic                          restart,
  output cmig_pkg::tri_t                     tri_out
);
  import cmig_pkg::*;

  // configuration registers
  logic [CNT_W-1:0] around_r;
  logic [CNT_W-1:0] along_r;
  logic             close_bottom_r;
  logic             close_top_r;

  // walk state
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] level_r, level_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;
  logic             half_r, half_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;

  // derived values
  logic [CNT_W-1:0]   c_eff, l_eff;
  logic [2*CNT_W-1:0] prod;
  logic [IDX_W-1:0]   c17, k, ring_verts, top_centre;

  // state as seen after an optional restart
  logic             start;
  logic             phase_ok;
  phase_t           ph;
  logic [CNT_W-1:0] lvl;
  logic [SEG_W-1:0] seg;
  logic             half;
  logic [IDX_W-1:0] base;

  logic [CNT_W-1:0] s_inc, n9, lvl_inc;
  logic             seg_wrap, lvl_wrap;
  logic [IDX_W-1:0] s17, n17, bc;
  logic [IDX_W-1:0] va, vb, vc;
  phase_t           after_bottom;

  // saturated segment counts
  always_comb begin
    if (around_r < CNT_W'(MIN_AROUND)) begin
      c_eff = CNT_W'(MIN_AROUND);
    end else if (around_r > CNT_W'(MAX_AROUND)) begin
      c_eff = CNT_W'(MAX_AROUND);
    end else begin
      c_eff = around_r;
    end
    if (along_r < CNT_W'(MIN_ALONG)) begin
      l_eff = CNT_W'(MIN_ALONG);
    end else if (along_r > CNT_W'(MAX_ALONG)) begin
      l_eff = CNT_W'(MAX_ALONG);
    end else begin
      l_eff = along_r;
    end
  end

  // ring vertex count and centre vertices
  assign prod       = {{CNT_W{1'b0}}, c_eff} * {{CNT_W{1'b0}}, l_eff};
  assign k          = prod[IDX_W-1:0];
  assign c17        = IDX_W'(c_eff);
  assign ring_verts = k + c17;
  assign top_centre = ring_verts + IDX_W'(close_bottom_r);

  // restart on request or on a state that cannot belong to this mesh
  assign phase_ok = (phase_r == PH_SIDE) || (phase_r == PH_BOTTOM) || (phase_r == PH_TOP);
  assign start    = restart || !phase_ok || ({1'b0, seg_r} >= c_eff) || (level_r >= l_eff);
  assign ph       = start ? PH_SIDE : phase_r;
  assign lvl      = start ? '0 : level_r;
  assign seg      = start ? '0 : seg_r;
  assign half     = start ? 1'b0 : half_r;
  assign base     = start ? '0 : base_r;

  // segment neighbours
  assign s_inc    = {1'b0, seg} + CNT_W'(1);
  assign seg_wrap = (s_inc == c_eff);
  assign n9       = seg_wrap ? '0 : s_inc;
  assign s17      = IDX_W'(seg);
  assign n17      = IDX_W'(n9);
  assign bc       = base + c17;
  assign lvl_inc  = lvl + CNT_W'(1);
  assign lvl_wrap = (lvl_inc == l_eff);

  assign after_bottom = close_top_r ? PH_TOP : PH_SIDE;

  // triangle indices and next walk state
  always_comb begin
    phase_nxt = ph;
    level_nxt = lvl;
    seg_nxt   = seg;
    half_nxt  = half;
    base_nxt  = base;
    va        = '0;
    vb        = '0;
    vc        = '0;
    unique case (ph)
      PH_SIDE: begin
        if (!half) begin
          va = base + s17;
          vb = base + n17;
          vc = bc + s17;
        end else begin
          va = bc + s17;
          vb = base + n17;
          vc = bc + n17;
        end
        half_nxt = !half;
        if (half) begin
          seg_nxt = s_inc[SEG_W-1:0];
          if (seg_wrap) begin
            seg_nxt   = '0;
            level_nxt = lvl_inc;
            base_nxt  = bc;
            if (lvl_wrap) begin
              level_nxt = '0;
              base_nxt  = '0;
              phase_nxt = close_bottom_r ? PH_BOTTOM : after_bottom;
            end
          end
        end
      end
      PH_BOTTOM: begin
        va      = ring_verts;
        vb      = n17;
        vc      = s17;
        seg_nxt = s_inc[SEG_W-1:0];
        if (seg_wrap) begin
          seg_nxt   = '0;
          phase_nxt = after_bottom;
        end
      end
      PH_TOP: begin
        va      = top_centre;
        vb      = k + s17;
        vc      = k + n17;
        seg_nxt = s_inc[SEG_W-1:0];
        if (seg_wrap) begin
          seg_nxt   = '0;
          phase_nxt = PH_SIDE;
        end
      end
      default: begin
        phase_nxt = PH_SIDE;
      end
    endcase
  end

  // result beat: last when the walk is back at its first triangle
  assign tri_out.vertex_a = va;
  assign tri_out.vertex_b = vb;
  assign tri_out.vertex_c = vc;
  assign tri_out.last     = (phase_nxt == PH_SIDE) && (level_nxt == '0) &&
                            (seg_nxt == '0) && !half_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      around_r       <= CNT_W'(8);
      along_r        <= CNT_W'(1);
      close_bottom_r <= 1'b0;
      close_top_r    <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AROUND:       around_r       <= cfg_wdata;
        CFG_ALONG:        along_r        <= cfg_wdata;
        CFG_CLOSE_BOTTOM: close_bottom_r <= cfg_wdata[0];
        CFG_CLOSE_TOP:    close_top_r    <= cfg_wdata[0];
        default:          close_top_r    <= close_top_r;
      endcase
    end
  end

  // walk state; any register write returns to the first triangle
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wen) begin
      phase_r <= PH_SIDE;
      level_r <= '0;
      seg_r   <= '0;
      half_r  <= 1'b0;
      base_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      seg_r   <= seg_nxt;
      half_r  <= half_nxt;
      base_r  <= base_nxt;
    end
  end

`ifndef SYNTHESIS
  // segment counter stays inside the ring
  a_seg_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, seg_r} < c_eff)
    else $error("segment index outside the ring");

  // ring base tracks ring level times segment count
  a_base_track: assert property (@(posedge clk) disable iff (!rst_n)
    base_r == ({{(IDX_W-CNT_W){1'b0}}, level_r} * {{(IDX_W-CNT_W){1'b0}}, c_eff}))
    else $error("ring base out of step with ring level");

  // a flagged last triangle leaves the walk at its start
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !cfg_wen && tri_out.last) |=>
      (phase_r == PH_SIDE && level_r == '0 && seg_r == '0 && !half_r))
    else $error("walk not at start after last triangle");

  // the bottom cap is only entered when enabled
  a_bottom_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BOTTOM) |-> close_bottom_r)
    else $error("bottom cap phase without close_bottom");
`endif

endmodule

`default_nettype wire

// ===== hdl/cmig_skid.sv =====
// cmig_skid: result register with a skid stage so the input ready is registered
// depends on cmig_pkg
`default_nettype none

module cmig_skid (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  s_valid,
  output logic       s_ready,
  input  wire cmig_pkg::tri_t s_data,
  output logic       m_valid,
  input  wire logic  m_ready,
  output cmig_pkg::tri_t m_data
);
  import cmig_pkg::*;

  logic main_valid_r;
  tri_t main_data_r;
  logic skid_valid_r;
  tri_t skid_data_r;
  logic s_fire;
  logic main_free;

  assign s_ready   = !skid_valid_r;
  assign s_fire    = s_valid && s_ready;
  assign main_free = m_ready || !main_valid_r;
  assign m_valid   = main_valid_r;
  assign m_data    = main_data_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      main_valid_r <= skid_valid_r || s_fire;
      skid_valid_r <= 1'b0;
    end else if (s_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data_r <= skid_valid_r ? skid_data_r : s_data;
    end else if (s_fire) begin
      skid_data_r <= s_data;
    end
  end

`ifndef SYNTHESIS
  // the skid stage only fills behind a full result register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid stage holds a beat while result register is empty");

  // a parked beat moves forward when the output drains
  a_skid_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && m_ready) |=> (main_valid_r && main_data_r == $past(skid_data_r)))
    else $error("skid beat lost or reordered");
`endif

endmodule

`default_nettype wire

// ===== hdl/cylinder_mesh_index_generator.sv =====
// cylinder_mesh_index_generator: top level, one cylinder triangle per request beat
// depends on cmig_pkg, cmig_walk and cmig_skid
`default_nettype none

//  channel | direction | handshake             | payload
//  in_     | slave     | in_tvalid / in_tready  | in_tdata[0] restart
//  out_    | master    | out_tvalid / out_tready| out_tdata vertex a,b,c; out_tlast last
//  cfg_    | write     | cfg_wen                | cfg_index, cfg_wdata
//
//  an accepted request beat's triangle is registered in the result register, or in the skid stage;
//  one triangle per clock while the output is not stalled, set by the walk counters and one 9x9 multiply for the caps
//  rst_n is synchronous: segments_around 8, segments_along 1, caps off, walk at start
//  a stalled output parks one beat in the skid stage, then in_tready drops
//  any register write returns the walk to its first triangle

module cylinder_mesh_index_generator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // bit 0 restart, bits 7:1 zero
  input  wire logic [cmig_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // bits 16:0 vertex_a, 33:17 vertex_b, 50:34 vertex_c, 55:51 zero
  output logic [cmig_pkg::OUT_DATA_W-1:0]           out_tdata,
  output logic                                     out_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_wen,
  input  wire logic [cmig_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cmig_pkg::CFG_W-1:0]           cfg_wdata
);
  import cmig_pkg::*;

  logic in_fire;
  tri_t tri_walk;
  tri_t tri_out;

  assign in_fire = in_tvalid && in_tready;

  // counters and index arithmetic
  cmig_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (in_fire),
    .restart   (in_tdata[0]),
    .tri_out   (tri_walk)
  );

  // result register and skid stage
  cmig_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (tri_walk),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (tri_out)
  );

  // pack the result beat
  assign out_tdata = {{(OUT_DATA_W - 3*IDX_W){1'b0}},
                      tri_out.vertex_c, tri_out.vertex_b, tri_out.vertex_a};
  assign out_tlast = tri_out.last;

endmodule

`default_nettype wire
